@@ hw/rtl/pts_pkg.sv @@
// Shared types and constants for the priority thread scheduler.
// No dependencies.
`timescale 1ns / 1ps
package pts_pkg;
  localparam int THREAD_COUNT = 8;
  localparam int SEM_COUNT    = 4;

  localparam logic [2:0] OP_SUSPEND = 3'd0;
  localparam logic [2:0] OP_RESUME  = 3'd1;
  localparam logic [2:0] OP_SEM_P   = 3'd2;
  localparam logic [2:0] OP_TRY_P   = 3'd3;
  localparam logic [2:0] OP_SEM_V   = 3'd4;
  localparam logic [2:0] OP_SLEEP   = 3'd5;
  localparam logic [2:0] OP_TICK    = 3'd6;
  localparam logic [2:0] OP_TIME    = 3'd7;

  localparam int REG_PRIO  = 0;
  localparam int REG_QUOTA = 1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [2:0]  target_thread;
    logic [1:0]  semaphore_index;
    logic [15:0] sleep_delay;
    logic        switch_lock;
  } pts_in_t;

  typedef struct packed {
    logic [2:0]  running_thread;
    logic        running_valid;
    logic        acquired;
    logic [15:0] tick_count;
  } pts_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_WALK, ST_WAKE, ST_SLICE, ST_FIN, ST_OUT
  } pts_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic walk;
    logic wake;
    logic slice;
    logic fin;
  } pts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic do_walk;
    logic is_tick;
    logic walk_last;
    logic wake_more;
  } pts_stat_t;
endpackage

@@ hw/rtl/pts_if.sv @@
// Valid/ready channel interface carrying a payload type.
// The payload type is a parameter; no package dependencies.
`timescale 1ns / 1ps
interface pts_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/priority_thread_scheduler_core.sv @@
// Priority thread scheduler: run queue, sleep queue and semaphores in hardware.
// Operation flow: exec, then finish, then the result beat; a sleep walks the sleep
//   queue one sleeper per step, a tick wakes expired sleepers and charges the slice.
// Handshake: the next beat is taken with the result, never before the last result.
// Reset (synchronous, rst_n low): thread zero ready and running, tick count zero.
// Depends on pts_pkg, pts_if, pts_ctrl and pts_dp.
`timescale 1ns / 1ps
module priority_thread_scheduler_core import pts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pts_if.sink         in_ch,
  pts_if.source       out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  pts_cmd_t  cmd;
  pts_stat_t stat;
  pts_out_t  res;

  pts_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .cmd
  );

  pts_dp u_dp (
    .clk, .rst_n, .cmd, .in_data(in_ch.data),
    .cfg_we, .cfg_index, .cfg_data, .stat, .res
  );

  assign out_ch.data = res;
endmodule

@@ hw/rtl/pts_ctrl.sv @@
// Controller state machine: accept a beat, run the operation, offer the result.
// Depends on pts_pkg.
`timescale 1ns / 1ps
module pts_ctrl import pts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  pts_stat_t stat,
  output pts_cmd_t  cmd
);
  pts_state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (stat.do_walk) state_nxt = ST_WALK;
        else if (stat.is_tick) state_nxt = ST_WAKE;
        else state_nxt = ST_FIN;
      end
      ST_WALK:  if (stat.walk_last) state_nxt = ST_FIN;
      ST_WAKE:  if (!stat.wake_more) state_nxt = ST_SLICE;
      ST_SLICE: state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_OUT;
      ST_OUT:   if (out_ready) state_nxt = in_valid ? ST_EXEC : ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_EXEC:  cmd.exec = 1'b1;
      ST_WALK:  cmd.walk = 1'b1;
      ST_WAKE:  cmd.wake = 1'b1;
      ST_SLICE: cmd.slice = 1'b1;
      ST_FIN:   cmd.fin = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
      end
      default: ;
    endcase
    cmd.load = in_ready & in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cmd.load |=> cmd.exec)
    else $error("exec missing after load");
  assert property (@(posedge clk) disable iff (!rst_n) cmd.fin |=> out_valid)
    else $error("result missing after finish");
  assert property (@(posedge clk) disable iff (!rst_n) !(cmd.exec && in_ready))
    else $error("accept during exec");
  assert property (@(posedge clk) disable iff (!rst_n) out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
endmodule

@@ hw/rtl/pts_dp.sv @@
// Scheduler datapath: queues, semaphores, counters, one step per command.
// Depends on pts_pkg.
`timescale 1ns / 1ps
module pts_dp import pts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  pts_cmd_t    cmd,
  input  pts_in_t     in_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output pts_stat_t   stat,
  output pts_out_t    res
);
  localparam int TW = $clog2(THREAD_COUNT);
  localparam int LW = $clog2(THREAD_COUNT + 1);
  localparam int SW = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;

  logic [31:0] prio_r;
  logic [7:0]  quota_r;
  pts_in_t     op_r;
  logic [TW-1:0] rq_r [THREAD_COUNT];
  logic [LW-1:0] rlen_r;
  logic [TW-1:0] sq_r [THREAD_COUNT];
  logic [LW-1:0] slen_r;
  logic [TW-1:0] wq_r [SEM_COUNT][THREAD_COUNT];
  logic [LW-1:0] wlen_r [SEM_COUNT];
  logic [15:0]   sem_r [SEM_COUNT];
  logic [15:0]   tt_r [THREAD_COUNT];
  logic [7:0]    bal_r [THREAD_COUNT];
  logic [TW-1:0] run_r;
  logic [15:0]   kt_r;
  logic [15:0]   d_r;
  logic [LW-1:0] pos_r;
  logic          busy_r;
  logic          acq_r;
  pts_out_t      res_r;

  function automatic logic [3:0] prio_of(input logic [31:0] p, input int t);
    if (t >= THREAD_COUNT) return 4'd0;
    return p[4*t +: 4];
  endfunction

  logic [TW-1:0] rq_n [THREAD_COUNT];
  logic [LW-1:0] rlen_n;
  logic [TW-1:0] sq_n [THREAD_COUNT];
  logic [LW-1:0] slen_n;
  logic [TW-1:0] wq_n [SEM_COUNT][THREAD_COUNT];
  logic [LW-1:0] wlen_n [SEM_COUNT];
  logic [15:0]   sem_n [SEM_COUNT];
  logic [15:0]   tt_n [THREAD_COUNT];
  logic [7:0]    bal_n [THREAD_COUNT];
  logic [TW-1:0] run_n;
  logic [15:0]   kt_n;
  logic [15:0]   d_n;
  logic [LW-1:0] pos_n;
  logic          busy_n;
  logic          acq_n;
  pts_out_t      res_n;

  logic [15:0] qv;
  assign qv = (quota_r == 8'd0) ? 16'd1 : {8'd0, quota_r};

  // sleep walk: one queue entry per cycle
  logic [TW-1:0] walk_thr;
  logic          walk_go;
  assign walk_thr = sq_r[pos_r[TW-1:0]];
  assign walk_go  = (pos_r < slen_r) && (tt_r[walk_thr] <= d_r);

  // status for the controller
  always_comb begin
    stat.do_walk   = (op_r.operation == OP_SLEEP) && (rlen_r != '0) &&
                     (op_r.sleep_delay != 16'd0) && (int'(slen_r) < THREAD_COUNT);
    stat.is_tick   = op_r.operation == OP_TICK;
    stat.walk_last = !walk_go;
    stat.wake_more = (slen_r != '0) && (tt_r[sq_r[0]] == 16'd0) &&
                     (int'(rlen_r) < THREAD_COUNT);
  end

  // next state for the current step
  always_comb begin
    logic busy, sem_ok, found, inrq, done;
    logic [TW-1:0] self, tg, h;
    logic [SW-1:0] si;
    logic [15:0] hv;
    int pos;
    rq_n = rq_r; rlen_n = rlen_r; sq_n = sq_r; slen_n = slen_r;
    wq_n = wq_r; wlen_n = wlen_r; sem_n = sem_r; tt_n = tt_r;
    bal_n = bal_r; run_n = run_r; kt_n = kt_r;
    d_n = d_r; pos_n = pos_r; busy_n = busy_r; acq_n = acq_r; res_n = res_r;
    busy = rlen_r != '0;
    self = run_r;
    tg = op_r.target_thread[TW-1:0];
    si = op_r.semaphore_index[SW-1:0];
    sem_ok = int'(op_r.semaphore_index) < SEM_COUNT;
    pos = 0; done = 1'b0; found = 1'b0; inrq = 1'b0; h = '0; hv = '0;
    if (cmd.exec) begin
      busy_n = busy;
      acq_n = 1'b0;
      case (op_r.operation)
        OP_SUSPEND: if (busy) begin
          if (bal_n[self] != 8'd0) bal_n[self] = bal_n[self] - 8'd1;
          if (bal_n[self] == 8'd0) begin
            found = 1'b0;
            for (int i = 0; i < THREAD_COUNT; i++) begin
              if (i < int'(rlen_n) && rq_n[i] == self) found = 1'b1;
              if (found && i + 1 < THREAD_COUNT) rq_n[i] = rq_n[i+1];
            end
            if (found) rlen_n = rlen_n - 1'b1;
          end
        end
        OP_RESUME: if (int'(op_r.target_thread) < THREAD_COUNT) begin
          for (int i = 0; i < THREAD_COUNT; i++)
            if (i < int'(rlen_r) && rq_r[i] == tg) inrq = 1'b1;
          if (bal_r[tg] != 8'd255) bal_n[tg] = bal_r[tg] + 8'd1;
          if (bal_r[tg] == 8'd0 && !inrq && int'(rlen_r) < THREAD_COUNT) begin
            pos = 0; done = 1'b0;
            for (int i = 0; i < THREAD_COUNT; i++)
              if (!done && i < int'(rlen_r) && prio_of(prio_r, int'(rq_r[i])) >=
                  prio_of(prio_r, int'(tg))) pos = i + 1;
              else done = 1'b1;
            for (int i = 0; i < THREAD_COUNT; i++)
              if (i > pos) rq_n[i] = rq_r[i-1];
              else if (i == pos) rq_n[i] = tg;
            rlen_n = rlen_r + 1'b1;
            tt_n[tg] = qv;
          end
        end
        OP_SEM_P: if (busy && sem_ok) begin
          if (sem_r[si] != 16'd0) sem_n[si] = sem_r[si] - 16'd1;
          else if (int'(wlen_r[si]) < THREAD_COUNT) begin
            found = 1'b0;
            for (int i = 0; i < THREAD_COUNT; i++) begin
              if (i < int'(rlen_n) && rq_n[i] == self) found = 1'b1;
              if (found && i + 1 < THREAD_COUNT) rq_n[i] = rq_n[i+1];
            end
            if (found) rlen_n = rlen_n - 1'b1;
            pos = 0; done = 1'b0;
            for (int i = 0; i < THREAD_COUNT; i++)
              if (!done && i < int'(wlen_r[si]) && prio_of(prio_r, int'(wq_r[si][i])) >=
                  prio_of(prio_r, int'(self))) pos = i + 1;
              else done = 1'b1;
            for (int i = 0; i < THREAD_COUNT; i++)
              if (i > pos) wq_n[si][i] = wq_r[si][i-1];
              else if (i == pos) wq_n[si][i] = self;
            wlen_n[si] = wlen_r[si] + 1'b1;
          end
        end
        OP_TRY_P: if (sem_ok && sem_r[si] != 16'd0) begin
          sem_n[si] = sem_r[si] - 16'd1;
          acq_n = 1'b1;
        end
        OP_SEM_V: if (sem_ok) begin
          if (sem_r[si] == 16'd0 && wlen_r[si] != '0 && int'(rlen_r) < THREAD_COUNT) begin
            h = wq_r[si][0];
            for (int i = 0; i + 1 < THREAD_COUNT; i++) wq_n[si][i] = wq_r[si][i+1];
            wlen_n[si] = wlen_r[si] - 1'b1;
            pos = 0; done = 1'b0;
            for (int i = 0; i < THREAD_COUNT; i++)
              if (!done && i < int'(rlen_r) && prio_of(prio_r, int'(rq_r[i])) >=
                  prio_of(prio_r, int'(h))) pos = i + 1;
              else done = 1'b1;
            for (int i = 0; i < THREAD_COUNT; i++)
              if (i > pos) rq_n[i] = rq_r[i-1];
              else if (i == pos) rq_n[i] = h;
            rlen_n = rlen_r + 1'b1;
            tt_n[h] = qv;
          end else if (sem_r[si] != 16'hFFFF) sem_n[si] = sem_r[si] + 16'd1;
        end
        OP_SLEEP: begin
          // start the walk; the queues change when it ends
          d_n = op_r.sleep_delay;
          pos_n = '0;
        end
        OP_TICK: begin
          kt_n = kt_r + 16'd1;
          if (slen_r != '0) tt_n[sq_r[0]] = tt_r[sq_r[0]] - 16'd1;
        end
        default: ;
      endcase
    end else if (cmd.walk) begin
      if (walk_go) begin
        // advance past one sleeper
        d_n = d_r - tt_r[walk_thr];
        pos_n = pos_r + 1'b1;
      end else begin
        // insert the caller into the sleep queue
        if (pos_r < slen_r) tt_n[walk_thr] = tt_r[walk_thr] - d_r;
        found = 1'b0;
        for (int i = 0; i < THREAD_COUNT; i++) begin
          if (i < int'(rlen_n) && rq_n[i] == self) found = 1'b1;
          if (found && i + 1 < THREAD_COUNT) rq_n[i] = rq_n[i+1];
        end
        if (found) rlen_n = rlen_n - 1'b1;
        tt_n[self] = d_r;
        for (int i = 0; i < THREAD_COUNT; i++)
          if (i > int'(pos_r)) sq_n[i] = sq_r[i-1];
          else if (i == int'(pos_r)) sq_n[i] = self;
        slen_n = slen_r + 1'b1;
      end
    end else if (cmd.wake) begin
      // wake one expired sleeper from the head
      if (stat.wake_more) begin
        h = sq_r[0];
        for (int i = 0; i + 1 < THREAD_COUNT; i++) sq_n[i] = sq_r[i+1];
        slen_n = slen_r - 1'b1;
        pos = 0; done = 1'b0;
        for (int i = 0; i < THREAD_COUNT; i++)
          if (!done && i < int'(rlen_r) && prio_of(prio_r, int'(rq_r[i])) >=
              prio_of(prio_r, int'(h))) pos = i + 1;
          else done = 1'b1;
        for (int i = 0; i < THREAD_COUNT; i++)
          if (i > pos) rq_n[i] = rq_r[i-1];
          else if (i == pos) rq_n[i] = h;
        rlen_n = rlen_r + 1'b1;
        tt_n[h] = qv;
      end
    end else if (cmd.slice) begin
      // charge the head one tick and rotate it when its slice runs out
      if (rlen_r != '0) begin
        h = rq_r[0];
        hv = tt_r[h] - 16'd1;
        tt_n[h] = hv;
        if (hv == 16'd0) begin
          pos = 0; done = 1'b0;
          for (int i = 1; i < THREAD_COUNT; i++)
            if (!done && i < int'(rlen_r) && prio_of(prio_r, int'(rq_r[i])) >=
                prio_of(prio_r, int'(h))) pos = i;
            else done = 1'b1;
          for (int i = 0; i < THREAD_COUNT; i++)
            if (i < pos) rq_n[i] = rq_r[i+1];
            else if (i == pos) rq_n[i] = h;
          tt_n[h] = qv;
        end
      end
    end else if (cmd.fin) begin
      // pick the running thread and form the result
      found = 1'b0;
      for (int i = 0; i < THREAD_COUNT; i++)
        if (i < int'(rlen_r) && rq_r[i] == run_r) found = 1'b1;
      if (rlen_r != '0 && (!busy_r || !found || !op_r.switch_lock)) run_n = rq_r[0];
      res_n.running_thread = (rlen_r != '0) ? 3'(run_n) : 3'd0;
      res_n.running_valid  = rlen_r != '0;
      res_n.acquired       = acq_r;
      res_n.tick_count     = kt_r;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prio_r <= '0; quota_r <= 8'd4; rlen_r <= LW'(1); slen_r <= '0;
      run_r <= '0; kt_r <= '0;
      for (int i = 0; i < THREAD_COUNT; i++) begin
        rq_r[i] <= '0; tt_r[i] <= 16'd4; bal_r[i] <= (i == 0) ? 8'd1 : 8'd0;
      end
      for (int s = 0; s < SEM_COUNT; s++) begin
        wlen_r[s] <= '0; sem_r[s] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'(REG_PRIO)) prio_r <= cfg_data;
        else quota_r <= cfg_data[7:0];
      end
      rq_r <= rq_n; rlen_r <= rlen_n; slen_r <= slen_n; wlen_r <= wlen_n;
      sem_r <= sem_n; tt_r <= tt_n; bal_r <= bal_n; run_r <= run_n; kt_r <= kt_n;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) op_r <= in_data;
    sq_r <= sq_n; wq_r <= wq_n;
    d_r <= d_n; pos_r <= pos_n; busy_r <= busy_n; acq_r <= acq_n;
    res_r <= res_n;
  end
  assign res = res_r;

  assert property (@(posedge clk) disable iff (!rst_n) int'(rlen_r) <= THREAD_COUNT)
    else $error("ready queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) int'(slen_r) <= THREAD_COUNT)
    else $error("sleep queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && op_r.operation != OP_TICK |=> kt_r == $past(kt_r))
    else $error("tick count moved without tick");
endmodule

@@ tb/tb.sv @@
// Self-checking testbench for priority_thread_scheduler_core.
// Predicts every result beat from its own scheduler model and compares it field
// by field. Depends on pts_pkg, pts_if and the core.
`timescale 1ns / 1ps
module tb;
  import pts_pkg::*;

  typedef logic [7:0][2:0] thr_queue_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;

  pts_if #(.T(pts_in_t))  in_ch (clk);
  pts_if #(.T(pts_out_t)) out_ch (clk);

  priority_thread_scheduler_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // scheduler shadow state
  logic [31:0] prio_reg;
  logic [7:0]  quota_reg;
  thr_queue_t  run_q;
  int          run_len;
  thr_queue_t  sleep_q;
  int          sleep_len;
  thr_queue_t  wait_q [4];
  int          wait_len [4];
  logic [15:0] sem_cnt [4];
  logic [15:0] slice_left [8];
  logic [7:0]  resume_cnt [8];
  logic [2:0]  cur_thread;
  logic [15:0] kernel_time;

  pts_out_t    sched_expect_q [$];
  int          errors = 0;
  int          beats_sent = 0;
  int          beats_checked = 0;
  int          acquire_hits = 0;
  int          op_hits [8];
  bit          idle_off = 0;
  int          hold_gen = 0;
  int          hold_len = 0;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  initial begin
    #20_000_000;
    $display("timeout at %0t", $time);
    $display("tb: failure");
    $finish;
  end

  // queue helpers on packed thread lists
  function automatic int find_thr(thr_queue_t q, int len, logic [2:0] t);
    for (int i = 0; i < len; i++) if (q[i] == t) return i;
    return len;
  endfunction

  function automatic logic [3:0] prio_of(logic [2:0] t);
    return prio_reg[4*t +: 4];
  endfunction

  function automatic logic [15:0] slice_len();
    return (quota_reg == 0) ? 16'd1 : {8'd0, quota_reg};
  endfunction

  task automatic q_insert(inout thr_queue_t q, inout int len, input int pos,
                          input logic [2:0] t);
    if (len >= 8 || pos > len) return;
    for (int i = len; i > pos; i--) q[i] = q[i-1];
    q[pos] = t;
    len++;
  endtask

  task automatic q_remove(inout thr_queue_t q, inout int len, input int pos);
    if (pos >= len) return;
    for (int i = pos; i < len - 1; i++) q[i] = q[i+1];
    len--;
  endtask

  task automatic q_prio_insert(inout thr_queue_t q, inout int len, input logic [2:0] t);
    int pos;
    pos = 0;
    while (pos < len && prio_of(q[pos]) >= prio_of(t)) pos++;
    q_insert(q, len, pos, t);
  endtask

  task automatic reset_shadow();
    prio_reg = '0;
    quota_reg = 8'd4;
    run_q = '0;
    run_len = 1;
    sleep_q = '0;
    sleep_len = 0;
    for (int s = 0; s < 4; s++) begin
      wait_q[s] = '0;
      wait_len[s] = 0;
      sem_cnt[s] = '0;
    end
    for (int t = 0; t < 8; t++) begin
      slice_left[t] = 16'd4;
      resume_cnt[t] = '0;
    end
    resume_cnt[0] = 8'd1;
    cur_thread = '0;
    kernel_time = '0;
  endtask

  // advance the shadow scheduler by one operation and form its result
  task automatic schedule_op(input pts_in_t op, output pts_out_t res);
    bit          busy;
    logic [2:0]  self;
    logic [2:0]  t;
    logic [1:0]  s;
    logic [15:0] d;
    int          pos;
    bit          got;
    busy = run_len > 0;
    self = cur_thread;
    s = op.semaphore_index;
    got = 0;
    case (op.operation)
      OP_SUSPEND: begin
        if (busy) begin
          if (resume_cnt[self] > 0) resume_cnt[self]--;
          if (resume_cnt[self] == 0) q_remove(run_q, run_len, find_thr(run_q, run_len, self));
        end
      end
      OP_RESUME: begin
        t = op.target_thread;
        if (resume_cnt[t] == 0 && find_thr(run_q, run_len, t) == run_len && run_len < 8) begin
          q_prio_insert(run_q, run_len, t);
          slice_left[t] = slice_len();
        end
        if (resume_cnt[t] < 8'd255) resume_cnt[t]++;
      end
      OP_SEM_P: begin
        if (busy) begin
          if (sem_cnt[s] > 0) sem_cnt[s]--;
          else if (wait_len[s] < 8) begin
            q_remove(run_q, run_len, find_thr(run_q, run_len, self));
            q_prio_insert(wait_q[s], wait_len[s], self);
          end
        end
      end
      OP_TRY_P: begin
        if (sem_cnt[s] > 0) begin
          sem_cnt[s]--;
          got = 1;
        end
      end
      OP_SEM_V: begin
        if (sem_cnt[s] == 0 && wait_len[s] > 0 && run_len < 8) begin
          t = wait_q[s][0];
          q_remove(wait_q[s], wait_len[s], 0);
          q_prio_insert(run_q, run_len, t);
          slice_left[t] = slice_len();
        end else if (sem_cnt[s] != 16'hFFFF) begin
          sem_cnt[s]++;
        end
      end
      OP_SLEEP: begin
        if (busy && op.sleep_delay != 0 && sleep_len < 8) begin
          d = op.sleep_delay;
          pos = 0;
          while (pos < sleep_len && slice_left[sleep_q[pos]] <= d) begin
            d = d - slice_left[sleep_q[pos]];
            pos++;
          end
          if (pos < sleep_len) slice_left[sleep_q[pos]] = slice_left[sleep_q[pos]] - d;
          q_remove(run_q, run_len, find_thr(run_q, run_len, self));
          slice_left[self] = d;
          q_insert(sleep_q, sleep_len, pos, self);
        end
      end
      OP_TICK: begin
        kernel_time = kernel_time + 16'd1;
        if (sleep_len > 0) begin
          slice_left[sleep_q[0]] = slice_left[sleep_q[0]] - 16'd1;
          while (sleep_len > 0 && slice_left[sleep_q[0]] == 0 && run_len < 8) begin
            t = sleep_q[0];
            q_remove(sleep_q, sleep_len, 0);
            q_prio_insert(run_q, run_len, t);
            slice_left[t] = slice_len();
          end
        end
        if (run_len > 0) begin
          t = run_q[0];
          slice_left[t] = slice_left[t] - 16'd1;
          if (slice_left[t] == 0) begin
            q_remove(run_q, run_len, 0);
            q_prio_insert(run_q, run_len, t);
            slice_left[t] = slice_len();
          end
        end
      end
      default: ;
    endcase
    res = '0;
    if (run_len > 0) begin
      if (!busy || find_thr(run_q, run_len, cur_thread) == run_len || !op.switch_lock)
        cur_thread = run_q[0];
      res.running_thread = cur_thread;
      res.running_valid = 1'b1;
    end
    res.acquired = got;
    res.tick_count = kernel_time;
  endtask

  // send one beat, with random idle cycles ahead of it
  task automatic send_op(input pts_in_t op);
    pts_out_t res;
    while (!idle_off && $urandom_range(0, 99) < 20) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= op;
    do @(posedge clk); while (!in_ch.ready);
    schedule_op(op, res);
    sched_expect_q.push_back(res);
    beats_sent++;
    op_hits[op.operation]++;
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (sched_expect_q.size() != 0 && guard < 200_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  // write one register; the block must be idle
  task automatic write_reg(input int idx, input logic [31:0] val);
    stop_sending();
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx[0:0];
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_PRIO) prio_reg = val;
    else quota_reg = val[7:0];
  endtask

  function automatic pts_in_t mk_op(logic [2:0] o, logic [2:0] t, logic [1:0] s,
                                    logic [15:0] d, logic l);
    pts_in_t op;
    op.operation = o;
    op.target_thread = t;
    op.semaphore_index = s;
    op.sleep_delay = d;
    op.switch_lock = l;
    return op;
  endfunction

  // weighted random operation: mostly traffic that keeps threads cycling
  function automatic pts_in_t rand_op();
    pts_in_t     op;
    int          r;
    logic [31:0] raw;
    raw = $urandom;
    op = raw[$bits(pts_in_t)-1:0];
    r = $urandom_range(0, 99);
    if (r < 25) op.operation = OP_RESUME;
    else if (r < 50) op.operation = OP_TICK;
    else if (r < 60) op.operation = OP_SEM_P;
    else if (r < 67) op.operation = OP_TRY_P;
    else if (r < 80) op.operation = OP_SEM_V;
    else if (r < 87) op.operation = OP_SUSPEND;
    else if (r < 95) op.operation = OP_SLEEP;
    else op.operation = OP_TIME;
    if ($urandom_range(0, 9) != 0) op.sleep_delay = 16'($urandom_range(0, 12));
    return op;
  endfunction

  // count down a requested receiver hold-off
  int hold_left = 0;
  int hold_seen = 0;
  bit hold_on = 0;
  always @(posedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen = hold_gen;
      hold_left = hold_len;
    end
    if (hold_left > 0) hold_left--;
    hold_on <= hold_left > 0;
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    pts_out_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        beats_checked++;
        if (sched_expect_q.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, out_ch.data);
          errors++;
        end else begin
          want = sched_expect_q.pop_front();
          if (out_ch.data.running_thread !== want.running_thread) begin
            $display("%0t: running_thread exp %0d got %0d", $time,
                     want.running_thread, out_ch.data.running_thread);
            errors++;
          end
          if (out_ch.data.running_valid !== want.running_valid) begin
            $display("%0t: running_valid exp %0d got %0d", $time,
                     want.running_valid, out_ch.data.running_valid);
            errors++;
          end
          if (out_ch.data.acquired !== want.acquired) begin
            $display("%0t: acquired exp %0d got %0d", $time,
                     want.acquired, out_ch.data.acquired);
            errors++;
          end
          if (out_ch.data.tick_count !== want.tick_count) begin
            $display("%0t: tick_count exp %0d got %0d", $time,
                     want.tick_count, out_ch.data.tick_count);
            errors++;
          end
          if (want.acquired) acquire_hits++;
        end
      end
      // hold off on request, else stall at random (never while idle_off is set)
      if (hold_on) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= idle_off ? 1'b1 : ($urandom_range(0, 99) >= 20);
      end
    end
  end

  task automatic test_directed();
    send_op(mk_op(OP_TIME, 3'd0, 2'd0, 16'd0, 1'b0));
    send_op(mk_op(OP_TRY_P, 3'd0, 2'd3, 16'd0, 1'b0));      // count zero
    send_op(mk_op(OP_SEM_V, 3'd0, 2'd3, 16'd0, 1'b0));
    send_op(mk_op(OP_TRY_P, 3'd0, 2'd3, 16'd0, 1'b1));      // taken
    send_op(mk_op(OP_RESUME, 3'd7, 2'd0, 16'd0, 1'b1));     // lock holds thread 0
    send_op(mk_op(OP_RESUME, 3'd7, 2'd0, 16'd0, 1'b0));     // balance only
    send_op(mk_op(OP_SEM_P, 3'd0, 2'd2, 16'd0, 1'b0));      // block on empty sem
    send_op(mk_op(OP_SLEEP, 3'd0, 2'd0, 16'd0, 1'b0));      // zero delay
    send_op(mk_op(OP_SLEEP, 3'd0, 2'd0, 16'd65535, 1'b1));  // longest sleep
    send_op(mk_op(OP_SUSPEND, 3'd0, 2'd0, 16'd0, 1'b0));    // already idle
    send_op(mk_op(OP_SUSPEND, 3'd0, 2'd0, 16'd0, 1'b0));    // idle caller
    send_op(mk_op(OP_SEM_P, 3'd0, 2'd1, 16'd0, 1'b0));
    send_op(mk_op(OP_SLEEP, 3'd0, 2'd0, 16'd3, 1'b0));
    send_op(mk_op(OP_TICK, 3'd0, 2'd0, 16'd0, 1'b0));
    send_op(mk_op(OP_SEM_V, 3'd0, 2'd2, 16'd0, 1'b1));      // wake waiter, leave idle
    send_op(mk_op(OP_RESUME, 3'd3, 2'd0, 16'd0, 1'b1));
    send_op(mk_op(OP_RESUME, 3'd5, 2'd0, 16'd0, 1'b0));
    for (int i = 0; i < 6; i++) send_op(mk_op(OP_TICK, 3'd0, 2'd0, 16'd0, i[0]));
    send_op(mk_op(OP_TIME, 3'd0, 2'd0, 16'd0, 1'b1));
  endtask

  // drive the resume balance of one thread up to saturation
  task automatic test_resume_saturation();
    for (int i = 0; i < 260; i++) send_op(mk_op(OP_RESUME, 3'd6, 2'd0, 16'd0, 1'b1));
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_op(rand_op());
  endtask

  // stall the result side long enough to back up the input
  task automatic test_backpressure();
    hold_len = 200;
    hold_gen++;
    test_random(40);
  endtask

  task automatic test_config_sweep();
    logic [31:0] prios [4];
    logic [7:0]  quotas [4];
    prios = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7654_3210, $urandom};
    quotas = '{8'd1, 8'd255, 8'd0, 8'($urandom_range(2, 6))};
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_PRIO, prios[p]);
      write_reg(REG_QUOTA, {24'd0, quotas[p]});
      idle_off = (p == 2);
      test_random(400);
      idle_off = 0;
    end
  endtask

  initial begin
    int guard;
    for (int i = 0; i < 8; i++) op_hits[i] = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    reset_shadow();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_resume_saturation();
    test_backpressure();
    stop_sending();
    wait_drained();
    test_config_sweep();
    write_reg(REG_QUOTA, 32'd3);
    test_random(200);
    stop_sending();

    guard = 0;
    while (sched_expect_q.size() != 0 && guard < 200_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (sched_expect_q.size() != 0) begin
      $display("%0d expected results never arrived", sched_expect_q.size());
      errors++;
    end
    $display("covered %0d operations (%0d resume, %0d tick, %0d sleep), %0d results checked",
             beats_sent, op_hits[OP_RESUME], op_hits[OP_TICK], op_hits[OP_SLEEP],
             beats_checked);
    $display("try-P acquisitions %0d, errors %0d", acquire_hits, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
